/* hw/rtl/tcd_pkg.sv */
// Shared types and constants for the TCP chunk header deframer.
// Used by tcd_hdr_check, tcd_track and tcp_chunk_header_deframer; no dependencies.
package tcd_pkg;

  localparam int unsigned HDR_BYTES = 8;
  localparam int unsigned POS_W     = $clog2(HDR_BYTES + 1);
  localparam int unsigned HDR_IDX_W = $clog2(HDR_BYTES - 1);
  localparam int unsigned MAX_W     = 24;
  localparam int unsigned SIZE_W    = 32;

  localparam logic [POS_W-1:0] POS_FULL = POS_W'(HDR_BYTES);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(HDR_BYTES - 1);
  localparam logic [MAX_W-1:0] MAX_RESET = 24'd65536;

  localparam logic [2:0] KIND_HEL = 3'd0;
  localparam logic [2:0] KIND_ACK = 3'd1;
  localparam logic [2:0] KIND_ERR = 3'd2;
  localparam logic [2:0] KIND_MSG = 3'd3;
  localparam logic [2:0] KIND_OPN = 3'd4;
  localparam logic [2:0] KIND_CLO = 3'd5;

  localparam logic [1:0] FLAG_C = 2'd0;
  localparam logic [1:0] FLAG_F = 2'd1;
  localparam logic [1:0] FLAG_A = 2'd2;

  localparam logic [7:0] CH_C = 8'h43;
  localparam logic [7:0] CH_F = 8'h46;
  localparam logic [7:0] CH_A = 8'h41;

  localparam logic [23:0] TYPE_HEL = "HEL";
  localparam logic [23:0] TYPE_ACK = "ACK";
  localparam logic [23:0] TYPE_ERR = "ERR";
  localparam logic [23:0] TYPE_MSG = "MSG";
  localparam logic [23:0] TYPE_OPN = "OPN";
  localparam logic [23:0] TYPE_CLO = "CLO";

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_TYPE  = 3'd1;
  localparam logic [2:0] ST_TOO_LARGE = 3'd2;
  localparam logic [2:0] ST_TOO_SMALL = 3'd3;
  localparam logic [2:0] ST_HALTED    = 3'd4;

  typedef logic [HDR_BYTES-2:0][7:0] hdr_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic [1:0]        flag;
    logic [SIZE_W-1:0] size;
    logic [2:0]        status;
  } chk_t;

  typedef struct packed {
    logic [7:0]        data_out;
    logic              in_header;
    logic              header_done;
    logic [2:0]        message_kind;
    logic [1:0]        chunk_flag;
    logic [SIZE_W-1:0] chunk_total_size;
    logic              chunk_last;
    logic [2:0]        status;
  } res_t;

endpackage

/* hw/rtl/tcp_chunk_header_deframer.sv */
// Top level of the TCP chunk header deframer: input register, tracker, result register.
// Depends on tcd_pkg and tcd_track.
//
//   port group   direction  content
//   in_*         request in  one stream byte
//   out_*        request out one result per byte
//   cfg_*        request in  max_chunk_bytes write
//
// One byte per cycle unless out_ready stalls; each byte passes input then result register.
// The tracker state updates as a byte moves from the input to the result register.
// rst_n clears state and halt and sets the size limit to 65536; cfg_ready is always high.
// A stalled out_ready holds the result; the input register fills and then drops in_ready.
module tcp_chunk_header_deframer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  in_rx_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  out_data_out,
  output logic                        out_in_header,
  output logic                        out_header_done,
  output logic [2:0]                  out_message_kind,
  output logic [1:0]                  out_chunk_flag,
  output logic [tcd_pkg::SIZE_W-1:0]  out_chunk_total_size,
  output logic                        out_chunk_last,
  output logic [2:0]                  out_status,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [tcd_pkg::MAX_W-1:0]   cfg_max_chunk_bytes
);

  logic                      in_vld_r;
  logic [7:0]                in_byte_r;
  logic                      out_vld_r;
  tcd_pkg::res_t             out_res_r;
  logic [tcd_pkg::MAX_W-1:0] max_r;
  logic                      out_free;
  logic                      step;
  tcd_pkg::res_t             res;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_vld_r || out_ready;
  assign step      = in_vld_r && out_free;
  assign in_ready  = !in_vld_r || out_free;

  tcd_track u_track (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .rx_byte   (in_byte_r),
    .max_bytes (max_r),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r     <= tcd_pkg::MAX_RESET;
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        max_r <= cfg_max_chunk_bytes;
      end
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (out_free) begin
        out_vld_r <= in_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_rx_byte;
    end
    if (step) begin
      out_res_r <= res;
    end
  end

  assign out_valid            = out_vld_r;
  assign out_data_out         = out_res_r.data_out;
  assign out_in_header        = out_res_r.in_header;
  assign out_header_done      = out_res_r.header_done;
  assign out_message_kind     = out_res_r.message_kind;
  assign out_chunk_flag       = out_res_r.chunk_flag;
  assign out_chunk_total_size = out_res_r.chunk_total_size;
  assign out_chunk_last       = out_res_r.chunk_last;
  assign out_status           = out_res_r.status;

endmodule

/* hw/rtl/tcd_hdr_check.sv */
// Header decode and check: type, flag and size of a complete 8-byte header.
// Depends on tcd_pkg.
module tcd_hdr_check (
  input  tcd_pkg::hdr_t                   hdr,
  input  logic [7:0]                      last_byte,
  input  logic [tcd_pkg::MAX_W-1:0]       max_bytes,
  output tcd_pkg::chk_t                   chk
);

  logic [23:0] type_key;
  logic        kind_ok;
  logic        flag_ok;
  logic [2:0]  kind;
  logic [1:0]  flag;
  logic [tcd_pkg::SIZE_W-1:0] size;

  assign type_key = {hdr[0], hdr[1], hdr[2]};
  assign size     = {last_byte, hdr[6], hdr[5], hdr[4]};

  always_comb begin
    kind_ok = 1'b1;
    case (type_key)
      tcd_pkg::TYPE_HEL: kind = tcd_pkg::KIND_HEL;
      tcd_pkg::TYPE_ACK: kind = tcd_pkg::KIND_ACK;
      tcd_pkg::TYPE_ERR: kind = tcd_pkg::KIND_ERR;
      tcd_pkg::TYPE_MSG: kind = tcd_pkg::KIND_MSG;
      tcd_pkg::TYPE_OPN: kind = tcd_pkg::KIND_OPN;
      tcd_pkg::TYPE_CLO: kind = tcd_pkg::KIND_CLO;
      default: begin
        kind    = tcd_pkg::KIND_HEL;
        kind_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    flag_ok = 1'b1;
    case (hdr[3])
      tcd_pkg::CH_C: flag = tcd_pkg::FLAG_C;
      tcd_pkg::CH_F: flag = tcd_pkg::FLAG_F;
      tcd_pkg::CH_A: flag = tcd_pkg::FLAG_A;
      default: begin
        flag    = tcd_pkg::FLAG_C;
        flag_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    chk.kind = kind;
    chk.flag = flag;
    chk.size = size;
    if (!kind_ok || !flag_ok || (kind != tcd_pkg::KIND_MSG && flag != tcd_pkg::FLAG_F)) begin
      chk.status = tcd_pkg::ST_BAD_TYPE;
    end else if (size > {{(tcd_pkg::SIZE_W - tcd_pkg::MAX_W){1'b0}}, max_bytes}) begin
      chk.status = tcd_pkg::ST_TOO_LARGE;
    end else if (size < tcd_pkg::SIZE_W'(tcd_pkg::HDR_BYTES)) begin
      chk.status = tcd_pkg::ST_TOO_SMALL;
    end else begin
      chk.status = tcd_pkg::ST_OK;
    end
  end

endmodule

/* hw/rtl/tcd_track.sv */
// Chunk tracking state: header position, stored header bytes, byte count, halt.
// Depends on tcd_pkg and tcd_hdr_check.
module tcd_track (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic [7:0]                  rx_byte,
  input  logic [tcd_pkg::MAX_W-1:0]   max_bytes,
  output tcd_pkg::res_t               res
);

  logic [tcd_pkg::POS_W-1:0] pos_r, pos_nxt;
  tcd_pkg::hdr_t             hdr_r, hdr_nxt;
  logic [2:0]                kind_r, kind_nxt;
  logic [1:0]                flag_r, flag_nxt;
  logic [tcd_pkg::MAX_W-1:0] size_r, size_nxt;
  logic [tcd_pkg::MAX_W-1:0] count_r, count_nxt;
  logic                      halted_r, halted_nxt;
  logic [tcd_pkg::MAX_W-1:0] count_inc;
  tcd_pkg::chk_t             chk;

  tcd_hdr_check u_check (
    .hdr       (hdr_r),
    .last_byte (rx_byte),
    .max_bytes (max_bytes),
    .chk       (chk)
  );

  assign count_inc = count_r + tcd_pkg::MAX_W'(1);

  always_comb begin
    pos_nxt    = pos_r;
    hdr_nxt    = hdr_r;
    kind_nxt   = kind_r;
    flag_nxt   = flag_r;
    size_nxt   = size_r;
    count_nxt  = count_r;
    halted_nxt = halted_r;

    res                  = '0;
    res.data_out         = rx_byte;
    res.status           = tcd_pkg::ST_OK;

    if (halted_r) begin
      res.status = tcd_pkg::ST_HALTED;
    end else if (pos_r != tcd_pkg::POS_FULL) begin
      res.in_header = 1'b1;
      pos_nxt       = pos_r + tcd_pkg::POS_W'(1);
      count_nxt     = count_inc;
      if (pos_r != tcd_pkg::POS_LAST) begin
        hdr_nxt[pos_r[tcd_pkg::HDR_IDX_W-1:0]] = rx_byte;
      end else begin
        res.chunk_total_size = chk.size;
        res.status           = chk.status;
        if (chk.status != tcd_pkg::ST_OK) begin
          halted_nxt = 1'b1;
        end else begin
          res.header_done  = 1'b1;
          res.message_kind = chk.kind;
          res.chunk_flag   = chk.flag;
          kind_nxt         = chk.kind;
          flag_nxt         = chk.flag;
          size_nxt         = chk.size[tcd_pkg::MAX_W-1:0];
          if (count_inc >= chk.size[tcd_pkg::MAX_W-1:0]) begin
            res.chunk_last = 1'b1;
            pos_nxt        = '0;
            count_nxt      = '0;
          end
        end
      end
    end else begin
      res.message_kind     = kind_r;
      res.chunk_flag       = flag_r;
      res.chunk_total_size = {{(tcd_pkg::SIZE_W - tcd_pkg::MAX_W){1'b0}}, size_r};
      count_nxt            = count_inc;
      if (count_inc >= size_r) begin
        res.chunk_last = 1'b1;
        pos_nxt        = '0;
        count_nxt      = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      kind_r   <= '0;
      flag_r   <= '0;
      size_r   <= '0;
      count_r  <= '0;
      halted_r <= 1'b0;
    end else if (step) begin
      pos_r    <= pos_nxt;
      kind_r   <= kind_nxt;
      flag_r   <= flag_nxt;
      size_r   <= size_nxt;
      count_r  <= count_nxt;
      halted_r <= halted_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      hdr_r <= hdr_nxt;
    end
  end

endmodule

/* sim/testbench.sv */
// Testbench for tcp_chunk_header_deframer: streams chunk headers and bodies, predicts
// every per-byte result and checks it field by field. Depends on tcd_pkg and the RTL.
module testbench;
  import tcd_pkg::*;

  localparam logic [23:0] TYPE_TEXT [6] = '{TYPE_HEL, TYPE_ACK, TYPE_ERR,
                                            TYPE_MSG, TYPE_OPN, TYPE_CLO};
  localparam logic [7:0]  FLAG_CHAR [3] = '{CH_C, CH_F, CH_A};
  localparam int unsigned QUIET_LIMIT = 2000;

  typedef enum {BREAK_TYPE, BREAK_FLAG, BREAK_NEEDS_F, BREAK_LARGE, BREAK_SMALL} fault_t;

  class chunk_tracker_t;
    logic [MAX_W-1:0]  max_bytes;
    int unsigned       hdr_pos;
    int unsigned       rcvd;
    logic [63:0]       hdr;
    logic [2:0]        kind_q;
    logic [1:0]        flag_q;
    logic [SIZE_W-1:0] size_q;
    bit                halted;
    int unsigned       errors;
    res_t              due_results[$];

    function new();
      max_bytes = MAX_RESET;
      hdr_pos   = 0;
      rcvd      = 0;
      hdr       = '0;
      kind_q    = KIND_HEL;
      flag_q    = FLAG_C;
      size_q    = '0;
      halted    = 1'b0;
      errors    = 0;
    endfunction

    function bit chunk_ends();
      if (rcvd >= size_q) begin
        hdr_pos = 0;
        rcvd    = 0;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void take_byte(logic [7:0] b);
      res_t              r;
      logic [2:0]        k;
      logic [1:0]        f;
      logic [2:0]        st;
      bit                kind_ok;
      bit                flag_ok;
      logic [SIZE_W-1:0] sz;
      r = '0;
      r.data_out = b;
      if (halted) begin
        r.status = ST_HALTED;
      end else if (hdr_pos < HDR_BYTES) begin
        r.in_header = 1'b1;
        hdr[hdr_pos*8 +: 8] = b;
        hdr_pos++;
        rcvd++;
        if (hdr_pos == HDR_BYTES) begin
          kind_ok = 1'b1;
          flag_ok = 1'b1;
          k = KIND_HEL;
          f = FLAG_C;
          case ({hdr[7:0], hdr[15:8], hdr[23:16]})
            TYPE_HEL: k = KIND_HEL;
            TYPE_ACK: k = KIND_ACK;
            TYPE_ERR: k = KIND_ERR;
            TYPE_MSG: k = KIND_MSG;
            TYPE_OPN: k = KIND_OPN;
            TYPE_CLO: k = KIND_CLO;
            default:  kind_ok = 1'b0;
          endcase
          case (hdr[31:24])
            CH_C:    f = FLAG_C;
            CH_F:    f = FLAG_F;
            CH_A:    f = FLAG_A;
            default: flag_ok = 1'b0;
          endcase
          sz = hdr[63:32];
          r.chunk_total_size = sz;
          if (!kind_ok || !flag_ok || (k != KIND_MSG && f != FLAG_F)) st = ST_BAD_TYPE;
          else if (sz > {8'd0, max_bytes}) st = ST_TOO_LARGE;
          else if (sz < HDR_BYTES) st = ST_TOO_SMALL;
          else st = ST_OK;
          r.status = st;
          if (st != ST_OK) begin
            halted = 1'b1;
          end else begin
            r.header_done  = 1'b1;
            r.message_kind = k;
            r.chunk_flag   = f;
            kind_q = k;
            flag_q = f;
            size_q = sz;
            r.chunk_last = chunk_ends();
          end
        end
      end else begin
        r.message_kind     = kind_q;
        r.chunk_flag       = flag_q;
        r.chunk_total_size = size_q;
        rcvd++;
        r.chunk_last = chunk_ends();
      end
      due_results.push_back(r);
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (due_results.size() == 0) begin
        $error("result with no byte pending: data_out %0h", got.data_out);
        errors++;
        return;
      end
      want = due_results.pop_front();
      compare("data_out", 32'(want.data_out), 32'(got.data_out));
      compare("in_header", 32'(want.in_header), 32'(got.in_header));
      compare("header_done", 32'(want.header_done), 32'(got.header_done));
      compare("message_kind", 32'(want.message_kind), 32'(got.message_kind));
      compare("chunk_flag", 32'(want.chunk_flag), 32'(got.chunk_flag));
      compare("chunk_total_size", want.chunk_total_size, got.chunk_total_size);
      compare("chunk_last", 32'(want.chunk_last), 32'(got.chunk_last));
      compare("status", 32'(want.status), 32'(got.status));
    endfunction
  endclass

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         in_rx_byte = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [7:0]         out_data_out;
  logic               out_in_header;
  logic               out_header_done;
  logic [2:0]         out_message_kind;
  logic [1:0]         out_chunk_flag;
  logic [SIZE_W-1:0]  out_chunk_total_size;
  logic               out_chunk_last;
  logic [2:0]         out_status;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [MAX_W-1:0]   cfg_max_chunk_bytes = '0;

  chunk_tracker_t     tracker;
  int unsigned        bytes_sent = 0;
  int unsigned        cur_max = 32'(MAX_RESET);
  int unsigned        quiet = 0;
  bit                 tx_calm = 1'b0;
  bit                 rx_calm = 1'b0;
  bit                 hold_req = 1'b0;

  tcp_chunk_header_deframer dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_rx_byte           (in_rx_byte),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_data_out         (out_data_out),
    .out_in_header        (out_in_header),
    .out_header_done      (out_header_done),
    .out_message_kind     (out_message_kind),
    .out_chunk_flag       (out_chunk_flag),
    .out_chunk_total_size (out_chunk_total_size),
    .out_chunk_last       (out_chunk_last),
    .out_status           (out_status),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_max_chunk_bytes  (cfg_max_chunk_bytes)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    res_t seen;
    if (rst_n) begin
      seen.data_out         = out_data_out;
      seen.in_header        = out_in_header;
      seen.header_done      = out_header_done;
      seen.message_kind     = out_message_kind;
      seen.chunk_flag       = out_chunk_flag;
      seen.chunk_total_size = out_chunk_total_size;
      seen.chunk_last       = out_chunk_last;
      seen.status           = out_status;
      if (cfg_valid && cfg_ready) tracker.max_bytes = cfg_max_chunk_bytes;
      if (in_valid && in_ready) tracker.take_byte(in_rx_byte);
      if (out_valid && out_ready) tracker.check_result(seen);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = 60;
        hold_req  = 1'b0;
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= rx_calm || ($urandom_range(0, 99) >= 10);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (!tx_calm && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_header(input logic [23:0] t, input logic [7:0] f,
                             input logic [31:0] sz);
    send_byte(t[23:16]);
    send_byte(t[15:8]);
    send_byte(t[7:0]);
    send_byte(f);
    send_byte(sz[7:0]);
    send_byte(sz[15:8]);
    send_byte(sz[23:16]);
    send_byte(sz[31:24]);
  endtask

  task automatic send_chunk(input logic [23:0] t, input logic [7:0] f,
                            input logic [31:0] sz);
    send_header(t, f, sz);
    repeat (sz - HDR_BYTES) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic random_chunks(input int unsigned count);
    int unsigned stop_at;
    logic [2:0]  kind;
    logic [7:0]  f;
    logic [31:0] sz;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) begin
      kind = 3'($urandom_range(KIND_HEL, KIND_CLO));
      f = (kind == KIND_MSG) ? FLAG_CHAR[$urandom_range(0, 2)] : CH_F;
      sz = ($urandom_range(0, 19) == 0) ? HDR_BYTES + $urandom_range(0, 400)
                                        : HDR_BYTES + $urandom_range(0, 24);
      if ($urandom_range(0, 9) == 0 && cur_max < 500) sz = cur_max;
      if (sz > cur_max) sz = cur_max;
      send_chunk(TYPE_TEXT[kind], f, sz);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.due_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_max(input logic [MAX_W-1:0] v);
    wait_drained();
    cfg_valid           <= 1'b1;
    cfg_max_chunk_bytes <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_max = 32'(v);
  endtask

  initial begin : stimulus
    fault_t      fault;
    logic [2:0]  kind;
    logic [23:0] t;
    logic [7:0]  f;
    logic [31:0] sz;
    tracker = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_chunk(TYPE_HEL, CH_F, HDR_BYTES);
    send_header(TYPE_MSG, CH_C, 10);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_chunk(TYPE_MSG, CH_A, HDR_BYTES);

    hold_req = 1'b1;
    random_chunks(250);

    write_max(24'd9);
    random_chunks(150);

    write_max(24'hFF_FFFF);
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    random_chunks(300);
    tx_calm = 1'b0;
    rx_calm = 1'b0;

    write_max(MAX_W'($urandom_range(9, 40)));
    random_chunks(150);

    write_max(MAX_W'($urandom_range(9, 24'hFF_FFFF)));
    random_chunks(150);

    // break one header at random, then feed bytes to the halted block
    random_chunks(60);
    fault = fault_t'($urandom_range(0, 4));
    t  = TYPE_MSG;
    f  = CH_F;
    sz = 16;
    case (fault)
      BREAK_TYPE: t = 24'($urandom_range(0, 24'hFF_FFFF));
      BREAK_FLAG: f = 8'($urandom_range(0, 255));
      BREAK_NEEDS_F: begin
        do kind = 3'($urandom_range(KIND_HEL, KIND_CLO)); while (kind == KIND_MSG);
        t = TYPE_TEXT[kind];
        f = $urandom_range(0, 1) ? CH_C : CH_A;
      end
      BREAK_LARGE: sz = $urandom_range(0, 1) ? 32'hFFFF_FFFF
                                             : cur_max + 1 + $urandom_range(0, 1000);
      BREAK_SMALL: sz = $urandom_range(0, HDR_BYTES - 1);
    endcase
    send_header(t, f, sz);
    repeat (20) send_byte(8'($urandom_range(0, 255)));

    wait_drained();
    if (tracker.errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end
endmodule
